>>> design/mmm_pkg.sv
// Shared types, codes and helpers for the matrix multiply block.
package mmm_pkg;

    localparam int CFG_BITS       = 4;
    localparam int CFG_INDEX_BITS = 4;
    localparam int SUM_BITS       = 40;
    localparam int POS_BITS       = 3;
    localparam int OP_BITS        = 2;
    localparam int IDX_BITS       = 6;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [OP_BITS-1:0] OP_LOAD_A  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD_B  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_COMPUTE = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ROWS_A      = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLS_RESULT = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INNER_LEN   = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TRANSPOSE_B = 4'd3;

    typedef struct packed {
        logic [CFG_BITS-1:0] rows_a;
        logic [CFG_BITS-1:0] cols_result;
        logic [CFG_BITS-1:0] inner_len;
        logic                transpose_b;
    } cfg_t;

    // 0 acts as 1, anything above the limit acts as the limit
    function automatic logic [CFG_BITS-1:0] clamp_dim(input logic [CFG_BITS-1:0] d,
                                                      input logic [CFG_BITS-1:0] dmax);
        logic [CFG_BITS-1:0] r;
        if (d == '0)
            r = CFG_BITS'(1);
        else if (d > dmax)
            r = dmax;
        else
            r = d;
        return r;
    endfunction

endpackage

>>> design/mmm_queue.sv
// Two-entry queue between the front and back parts.
module mmm_queue
    import mmm_pkg::*;
#(
    parameter int WIDTH = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> design/mmm_front.sv
// Input side: accepts beats, drops ignored ones, queues loads and computes.
module mmm_front
    import mmm_pkg::*;
#(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16
)
(
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [OP_BITS-1:0]   in_op,
    input  logic [IDX_BITS-1:0]  in_index,
    input  logic [ELEM_BITS-1:0] in_value,
    output logic                 q_valid,
    input  logic                 q_ready,
    output logic [OP_BITS+$clog2(MAX_DIM*MAX_DIM)+ELEM_BITS-1:0] q_data
);

    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

    typedef struct packed {
        logic [OP_BITS-1:0]   kind;
        logic [ADDR_W-1:0]    addr;
        logic [ELEM_BITS-1:0] value;
    } entry_t;

    logic [CFG_BITS-1:0]   ni, nj, nk;
    logic [2*CFG_BITS-1:0] size_a, size_b;
    logic                  keep;
    entry_t                entry;

    assign ni     = clamp_dim(cfg.rows_a, CFG_BITS'(MAX_DIM));
    assign nj     = clamp_dim(cfg.cols_result, CFG_BITS'(MAX_DIM));
    assign nk     = clamp_dim(cfg.inner_len, CFG_BITS'(MAX_DIM));
    assign size_a = ni * nk;
    assign size_b = nk * nj;

    always_comb
    begin
        unique case (in_op)
            OP_LOAD_A:  keep = (2*CFG_BITS)'(in_index) < size_a;
            OP_LOAD_B:  keep = (2*CFG_BITS)'(in_index) < size_b;
            OP_COMPUTE: keep = 1'b1;
            default:    keep = 1'b0;
        endcase
    end

    // an in-range index is below MAX_DIM squared, so the address cut is lossless
    assign entry.kind  = in_op;
    assign entry.addr  = ADDR_W'(in_index);
    assign entry.value = in_value;

    // dropped beats are taken only when the queue could take them anyway
    assign in_ready = q_ready;
    assign q_valid  = in_valid && keep;
    assign q_data   = entry;

endmodule

>>> design/mmm_back.sv
// Execution side: element stores, MAC sequencer, product pipeline, result register.
module mmm_back
    import mmm_pkg::*;
#(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  logic [OP_BITS+$clog2(MAX_DIM*MAX_DIM)+ELEM_BITS-1:0] q_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SUM_BITS-1:0]  out_sum,
    output logic [POS_BITS-1:0]  out_row,
    output logic [POS_BITS-1:0]  out_col,
    output logic                 out_last
);

    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int PROD_W = 2 * ELEM_BITS;

    typedef struct packed {
        logic [OP_BITS-1:0]   kind;
        logic [ADDR_W-1:0]    addr;
        logic [ELEM_BITS-1:0] value;
    } entry_t;

    typedef struct packed {
        logic             first;
        logic             last_k;
        logic             last_elem;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } tag_t;

    entry_t entry;

    logic [ELEM_BITS-1:0] a_mem [DEPTH];
    logic [ELEM_BITS-1:0] b_mem [DEPTH];

    logic [CFG_BITS-1:0] ni, nj, nk;
    logic [DIM_W-1:0]    ni_last, nj_last, nk_last;

    logic             busy_reg, busy_next;
    logic [DIM_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic             advance;
    logic [ADDR_W-1:0] a_addr, b_addr;
    tag_t             tag0;

    logic                     p1_valid_reg, p2_valid_reg;
    tag_t                     p1_tag_reg, p2_tag_reg;
    logic signed [ELEM_BITS-1:0] rd_a_reg, rd_b_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_BITS-1:0] prod_ext, acc_reg, acc_next;

    logic                out_valid_reg, out_valid_next;
    logic [SUM_BITS-1:0] out_sum_reg;
    logic [POS_BITS-1:0] out_row_reg, out_col_reg;
    logic                out_last_reg;
    logic                emit;

    assign entry = q_data;

    assign ni      = clamp_dim(cfg.rows_a, CFG_BITS'(MAX_DIM));
    assign nj      = clamp_dim(cfg.cols_result, CFG_BITS'(MAX_DIM));
    assign nk      = clamp_dim(cfg.inner_len, CFG_BITS'(MAX_DIM));
    assign ni_last = DIM_W'(ni - 1'b1);
    assign nj_last = DIM_W'(nj - 1'b1);
    assign nk_last = DIM_W'(nk - 1'b1);

    // next item is taken once the previous compute has issued all its reads
    assign q_ready = !busy_reg;
    // whole pipeline freezes while a finished result waits to be taken
    assign advance = !out_valid_reg || out_ready;

    assign a_addr = ADDR_W'(i_reg * nk + CFG_BITS'(k_reg));
    assign b_addr = cfg.transpose_b ? ADDR_W'(j_reg * nk + CFG_BITS'(k_reg))
                                    : ADDR_W'(k_reg * nj + CFG_BITS'(j_reg));

    assign tag0.first     = (k_reg == '0);
    assign tag0.last_k    = (k_reg == nk_last);
    assign tag0.last_elem = (i_reg == ni_last) && (j_reg == nj_last);
    assign tag0.row       = i_reg;
    assign tag0.col       = j_reg;

    always_comb
    begin
        busy_next = busy_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        k_next    = k_reg;
        if (!busy_reg)
        begin
            if (q_valid && entry.kind == OP_COMPUTE)
            begin
                busy_next = 1'b1;
                i_next    = '0;
                j_next    = '0;
                k_next    = '0;
            end
        end
        else if (advance)
        begin
            if (k_reg == nk_last)
            begin
                k_next = '0;
                if (j_reg == nj_last)
                begin
                    j_next = '0;
                    if (i_reg == ni_last)
                        busy_next = 1'b0;
                    else
                        i_next = i_reg + 1'b1;
                end
                else
                    j_next = j_reg + 1'b1;
            end
            else
                k_next = k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
            j_reg    <= '0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            i_reg    <= i_next;
            j_reg    <= j_next;
            k_reg    <= k_next;
        end
    end

    // stores: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (q_valid && !busy_reg && entry.kind == OP_LOAD_A)
            a_mem[entry.addr] <= entry.value;
        if (advance)
            rd_a_reg <= a_mem[a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && !busy_reg && entry.kind == OP_LOAD_B)
            b_mem[entry.addr] <= entry.value;
        if (advance)
            rd_b_reg <= b_mem[b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_tag_reg <= tag0;
            p2_tag_reg <= p1_tag_reg;
            prod_reg   <= rd_a_reg * rd_b_reg;
        end
    end

    // wider products wrap modulo 2^40, narrower ones sign-extend
    assign prod_ext = SUM_BITS'(prod_reg);
    assign acc_next = p2_tag_reg.first ? prod_ext : acc_reg + prod_ext;
    assign emit     = advance && p2_valid_reg && p2_tag_reg.last_k;

    always_ff @(posedge clk)
    begin
        if (advance && p2_valid_reg)
            acc_reg <= acc_next;
        if (emit)
        begin
            out_sum_reg  <= acc_next;
            out_row_reg  <= POS_BITS'(p2_tag_reg.row);
            out_col_reg  <= POS_BITS'(p2_tag_reg.col);
            out_last_reg <= p2_tag_reg.last_elem;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                p1_valid_reg <= busy_reg;
                p2_valid_reg <= p1_valid_reg;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_last  = out_last_reg;

endmodule

>>> design/matrix_matrix_multiply.sv
// Top level of the fixed-point dense matrix multiply block.
//
//  channel  | direction | signals                                 | content
//  ---------+-----------+-----------------------------------------+--------------------------
//  s_*      | in        | s_tvalid s_tready s_tdata s_tuser       | load A/B element, compute
//  m_*      | out       | m_tvalid m_tready m_tdata m_tlast       | one result element per beat
//  cfg_*    | in        | cfg_valid cfg_ready cfg_index cfg_data  | dimension/transpose regs
//
// A compute steps through the clamped rows_a*cols_result*inner_len products on the
// single multiplier; each passes registered read, multiply and accumulate stages.
// Items pass through a two-entry queue in front of the sequencer.
// Reset clears control state and sets the dimensions to 8, transpose off; element stores
// are undefined until loaded. While a result waits on m_tready the whole MAC pipeline
// holds; input stalls when the queue is full.
module matrix_matrix_multiply
    import mmm_pkg::*;
#(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [5:0] elem_index, [6+ELEM_BITS-1:6] elem_value, zero fill above
    input  logic [((IDX_BITS+ELEM_BITS+7)/8)*8-1:0] s_tdata,
    // [1:0] op
    input  logic [OP_BITS-1:0]        s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [39:0] sum_value, [42:40] out_row, [45:43] out_col, [47:46] zero
    output logic [47:0]               m_tdata,
    output logic                      m_tlast,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data
);

    localparam int ENTRY_W = OP_BITS + $clog2(MAX_DIM * MAX_DIM) + ELEM_BITS;

    cfg_t                cfg_reg;
    logic                f_valid, f_ready;
    logic [ENTRY_W-1:0]  f_data;
    logic                b_valid, b_ready;
    logic [ENTRY_W-1:0]  b_data;
    logic [SUM_BITS-1:0] sum_value;
    logic [POS_BITS-1:0] out_row, out_col;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows_a      <= CFG_BITS'(8);
            cfg_reg.cols_result <= CFG_BITS'(8);
            cfg_reg.inner_len   <= CFG_BITS'(8);
            cfg_reg.transpose_b <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROWS_A:      cfg_reg.rows_a      <= cfg_data;
                REG_COLS_RESULT: cfg_reg.cols_result <= cfg_data;
                REG_INNER_LEN:   cfg_reg.inner_len   <= cfg_data;
                REG_TRANSPOSE_B: cfg_reg.transpose_b <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    mmm_front #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_BITS)
    ) u_front (
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_index (s_tdata[IDX_BITS-1:0]),
        .in_value (s_tdata[IDX_BITS+ELEM_BITS-1:IDX_BITS]),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_data   (f_data)
    );

    mmm_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    mmm_back #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (b_valid),
        .q_ready   (b_ready),
        .q_data    (b_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sum   (sum_value),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, out_col, out_row, sum_value};

endmodule

>>> test/testbench.sv
// Testbench for the matrix multiply block: element loads, products, transposed products, settings.
`timescale 1ns / 1ps

module testbench;
    import mmm_pkg::*;

    localparam int DIM_LIMIT = 8;
    localparam int ELEM_W    = 16;
    localparam int DEPTH     = DIM_LIMIT * DIM_LIMIT;
    localparam int SDATA_W   = ((IDX_BITS + ELEM_W + 7) / 8) * 8;

    localparam logic [OP_BITS-1:0]        OP_UNUSED        = 2'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_UNUSED = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LAST_UNUSED  = 4'd15;

    typedef struct {
        logic [SUM_BITS-1:0] sum;
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
        logic                last;
    } product_elem_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [SDATA_W-1:0]        s_tdata   = '0;
    logic [OP_BITS-1:0]        s_tuser   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [47:0]               m_tdata;
    logic                      m_tlast;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]       cfg_data  = '0;

    matrix_matrix_multiply #(
        .MAX_DIM   (DIM_LIMIT),
        .ELEM_BITS (ELEM_W)
    ) dut (.*);

    // shadow of the block's registers and element stores
    cfg_t                     live_cfg;
    logic signed [ELEM_W-1:0] a_elems  [DEPTH];
    logic signed [ELEM_W-1:0] b_elems  [DEPTH];
    bit                       a_loaded [DEPTH];
    bit                       b_loaded [DEPTH];
    product_elem_t            product_q [$];

    bit idle_on       = 1'b1;
    int mismatches    = 0;
    int elems_checked = 0;
    int products_run  = 0;
    int loads_taken   = 0;
    int items_dropped = 0;
    int reg_writes    = 0;
    int work_items    = 0;
    int ready_gap     = 0;

    always #5 clk = ~clk;

    function automatic int dim_used(logic [CFG_BITS-1:0] d);
        if (d == '0)
            return 1;
        if (d > DIM_LIMIT)
            return DIM_LIMIT;
        return int'(d);
    endfunction

    function automatic int a_size();
        return dim_used(live_cfg.rows_a) * dim_used(live_cfg.inner_len);
    endfunction

    function automatic int b_size();
        return dim_used(live_cfg.inner_len) * dim_used(live_cfg.cols_result);
    endfunction

    // updates the shadow state and queues the result elements one item produces
    function automatic void model_item(logic [OP_BITS-1:0] op, logic [IDX_BITS-1:0] idx,
                                       logic [ELEM_W-1:0] val);
        int            ni;
        int            nj;
        int            nk;
        int            bi;
        longint        acc;
        product_elem_t pe;
        ni = dim_used(live_cfg.rows_a);
        nj = dim_used(live_cfg.cols_result);
        nk = dim_used(live_cfg.inner_len);
        case (op)
            OP_LOAD_A:
                if (idx < ni * nk) begin
                    a_elems[idx]  = val;
                    a_loaded[idx] = 1'b1;
                    loads_taken++;
                    work_items++;
                end else
                    items_dropped++;
            OP_LOAD_B:
                if (idx < nk * nj) begin
                    b_elems[idx]  = val;
                    b_loaded[idx] = 1'b1;
                    loads_taken++;
                    work_items++;
                end else
                    items_dropped++;
            OP_COMPUTE: begin
                for (int i = 0; i < ni; i++) begin
                    for (int j = 0; j < nj; j++) begin
                        acc = 0;
                        for (int k = 0; k < nk; k++) begin
                            bi = live_cfg.transpose_b ? (j * nk + k) : (k * nj + j);
                            acc += longint'(a_elems[i * nk + k]) * longint'(b_elems[bi]);
                        end
                        pe.sum  = acc[SUM_BITS-1:0];
                        pe.row  = POS_BITS'(i);
                        pe.col  = POS_BITS'(j);
                        pe.last = (i == ni - 1) && (j == nj - 1);
                        product_q.push_back(pe);
                    end
                end
                products_run++;
                work_items++;
            end
            default:
                items_dropped++;
        endcase
    endfunction

    task automatic flag_mismatch(string what);
        if (mismatches < 50)
            $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    // one input beat; valid stays high afterwards unless the next call idles
    task automatic send_item(logic [OP_BITS-1:0] op, logic [IDX_BITS-1:0] idx,
                             logic [ELEM_W-1:0] val);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= SDATA_W'({val, idx});
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        model_item(op, idx, val);
    endtask

    // hold input until every expected element is out, then let queued loads retire
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (product_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_writes++;
        case (index)
            REG_ROWS_A:      live_cfg.rows_a      = value;
            REG_COLS_RESULT: live_cfg.cols_result = value;
            REG_INNER_LEN:   live_cfg.inner_len   = value;
            REG_TRANSPOSE_B: live_cfg.transpose_b = value[0];
            default: ;
        endcase
    endtask

    task automatic set_shape(logic [CFG_BITS-1:0] rows, logic [CFG_BITS-1:0] cols,
                             logic [CFG_BITS-1:0] inner, logic tr);
        logic [CFG_BITS-1:0] tr_word;
        tr_word    = CFG_BITS'($urandom);
        tr_word[0] = tr;
        wait_drained();
        write_reg(REG_ROWS_A, rows);
        write_reg(REG_COLS_RESULT, cols);
        write_reg(REG_INNER_LEN, inner);
        write_reg(REG_TRANSPOSE_B, tr_word);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_INDEX_BITS'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                      CFG_BITS'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ELEM_W-1:0] pick_elem();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return '0;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_dim();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return CFG_BITS'($urandom_range(8, 15));
            default: return CFG_BITS'($urandom_range(1, 4));
        endcase
    endfunction

    // loads whatever the product will read that was never written, then computes
    task automatic run_product();
        int na;
        int nb;
        na = a_size();
        nb = b_size();
        for (int x = 0; x < na; x++)
            if (!a_loaded[x])
                send_item(OP_LOAD_A, IDX_BITS'(x), pick_elem());
        for (int x = 0; x < nb; x++)
            if (!b_loaded[x])
                send_item(OP_LOAD_B, IDX_BITS'(x), pick_elem());
        send_item(OP_COMPUTE, IDX_BITS'($urandom), ELEM_W'($urandom));
    endtask

    task automatic test_extremes();
        set_shape(4'd2, 4'd2, 4'd2, 1'b0);
        send_item(OP_LOAD_A, 6'd0, 16'h7FFF);
        send_item(OP_LOAD_A, 6'd1, 16'h8000);
        send_item(OP_LOAD_A, 6'd2, 16'h0001);
        send_item(OP_LOAD_A, 6'd3, 16'hFFFF);
        send_item(OP_LOAD_B, 6'd0, 16'h8000);
        send_item(OP_LOAD_B, 6'd1, 16'h7FFF);
        send_item(OP_LOAD_B, 6'd2, 16'h8000);
        send_item(OP_LOAD_B, 6'd3, 16'h0000);
        send_item(OP_COMPUTE, 6'd0, 16'h0000);
    endtask

    task automatic test_transpose();
        set_shape(4'd2, 4'd2, 4'd2, 1'b1);
        send_item(OP_COMPUTE, 6'd63, 16'hFFFF);
    endtask

    // out-of-range loads and the spare op code must leave the stores alone
    task automatic test_dropped_items();
        send_item(OP_LOAD_A, 6'd4, 16'h1234);
        send_item(OP_LOAD_B, 6'd63, 16'h5A5A);
        send_item(OP_UNUSED, 6'd0, 16'h7FFF);
        send_item(OP_COMPUTE, 6'd0, 16'h0000);
    endtask

    task automatic test_clamped_dims();
        set_shape(4'd0, 4'd0, 4'd0, 1'b0);
        run_product();
        set_shape(4'd9, 4'd0, 4'd1, 1'b0);
        run_product();
        set_shape(4'hF, 4'hC, 4'd1, 1'b1);
        run_product();
    endtask

    task automatic test_unused_regs();
        wait_drained();
        write_reg(REG_FIRST_UNUSED, 4'hF);
        write_reg(REG_LAST_UNUSED, 4'h0);
        cfg_valid <= 1'b0;
        run_product();
    endtask

    task automatic test_full_size();
        set_shape(4'd8, 4'd8, 4'd8, 1'b0);
        run_product();
        set_shape(4'd8, 4'd8, 4'd8, 1'b1);
        run_product();
    endtask

    task automatic test_random(int target);
        int start;
        start = work_items;
        while (work_items - start < target) begin
            // no idling near the end; some phases run with no idling at all
            idle_on = (work_items - start < target - 40) && ($urandom_range(0, 3) != 0);
            set_shape(pick_dim(), pick_dim(), pick_dim(), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(2, 5)) begin
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(0, 1) == 0)
                        send_item(OP_LOAD_A, IDX_BITS'($urandom_range(0, a_size() - 1)),
                                  pick_elem());
                    else
                        send_item(OP_LOAD_B, IDX_BITS'($urandom_range(0, b_size() - 1)),
                                  pick_elem());
                end
                if ($urandom_range(0, 4) == 0) begin
                    case ($urandom_range(0, 2))
                        0:       send_item(OP_LOAD_A, IDX_BITS'($urandom), pick_elem());
                        1:       send_item(OP_LOAD_B, IDX_BITS'($urandom), pick_elem());
                        default: send_item(OP_UNUSED, IDX_BITS'($urandom), ELEM_W'($urandom));
                    endcase
                end
                run_product();
                if ($urandom_range(0, 5) == 0)
                    wait_drained();
            end
        end
    endtask

    // receiver starts stall bursts of random length only while idling is on
    always @(posedge clk) begin
        if (ready_gap > 0) begin
            ready_gap--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            ready_gap = $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else
            m_tready <= 1'b1;
    end

    always @(posedge clk) begin
        product_elem_t want;
        if (rst_n && m_tvalid && m_tready) begin
            elems_checked++;
            if (product_q.size() == 0)
                flag_mismatch("result beat with nothing expected");
            else begin
                want = product_q.pop_front();
                if (m_tdata[SUM_BITS-1:0] !== want.sum)
                    flag_mismatch($sformatf("sum at (%0d,%0d): got %h want %h", want.row,
                                            want.col, m_tdata[SUM_BITS-1:0], want.sum));
                if (m_tdata[SUM_BITS+POS_BITS-1:SUM_BITS] !== want.row)
                    flag_mismatch($sformatf("row: got %0d want %0d",
                                            m_tdata[SUM_BITS+POS_BITS-1:SUM_BITS], want.row));
                if (m_tdata[SUM_BITS+2*POS_BITS-1:SUM_BITS+POS_BITS] !== want.col)
                    flag_mismatch($sformatf("col: got %0d want %0d",
                                            m_tdata[SUM_BITS+2*POS_BITS-1:SUM_BITS+POS_BITS],
                                            want.col));
                if (m_tlast !== want.last)
                    flag_mismatch($sformatf("tlast at (%0d,%0d): got %b want %b", want.row,
                                            want.col, m_tlast, want.last));
            end
        end
    end

    initial begin
        live_cfg.rows_a      = 4'd8;
        live_cfg.cols_result = 4'd8;
        live_cfg.inner_len   = 4'd8;
        live_cfg.transpose_b = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_transpose();
        test_dropped_items();
        test_clamped_dims();
        test_unused_regs();
        test_full_size();
        test_random(220);
        idle_on = 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);
        if (product_q.size() != 0)
            flag_mismatch($sformatf("%0d result elements never arrived", product_q.size()));
        $display("covered %0d products, %0d result beats, %0d element loads, %0d register writes",
                 products_run, elems_checked, loads_taken, reg_writes);
        $display("%0d items dropped as out of range or unused op; %0d mismatches",
                 items_dropped, mismatches);
        if (mismatches == 0)
            $display("[matrix_matrix_multiply] OK");
        else
            $display("[matrix_matrix_multiply] ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout: %0d result elements still expected", product_q.size());
        $display("[matrix_matrix_multiply] ERROR");
        $finish;
    end

endmodule
